// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/hda_pkg.sv =====
// Constants and helper functions for the Hamming distance accumulator.
package hda_pkg;

	localparam int WORD_W  = 64;
	localparam int DIST_W  = 17;
	localparam int ROOT_W  = 25;
	localparam int RAD_W   = DIST_W + 32;
	localparam logic [DIST_W-1:0] DIST_LIMIT = 17'd65536;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [RAD_W-1:0]  rad_t;

	// set bits in one byte
	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, b[i]};
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/hamming_distance_accumulator.sv =====
// Hamming distance accumulator: byte-serial popcount and bit-pair square root.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  cfg      | cfg_valid / cfg_ready | root_enable
//  in       | in_valid / in_ready   | left_word, right_word, last_word
//  out      | out_valid / out_ready | distance, root_fixed, overflow
//
// Each word pair is taken in one transfer in IDLE; COUNT then runs the
// shared byte counter over the XOR, byte by byte. A last word then posts the
// result from POST, after the ROOT square-root iteration when root_enable is set.
// arst_n clears the running total, the overflow flag, root_enable and the FSM.
// A result waits in the output register; a later last word holds in the post
// state until that register is free. cfg_ready is always high.
`include "assert_macros.svh"

module hamming_distance_accumulator
	import hda_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                root_enable,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WORD_W-1:0]   left_word,
	input  logic [WORD_W-1:0]   right_word,
	input  logic                last_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIST_W-1:0]   distance,
	output logic [ROOT_W-1:0]   root_fixed,
	output logic                overflow
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_ROOT  = 2'd2;
	localparam logic [1:0] ST_POST  = 2'd3;

	logic [1:0]        state_q;
	logic              root_en_q;
	logic [WORD_W-1:0] diff_q;
	logic              last_q;
	logic [2:0]        byte_q;
	dist_t             total_q;
	logic              sat_q;
	rad_t              rem_q;
	rad_t              res_q;
	rad_t              bit_q;
	logic [ROOT_W-1:0] root_q;

	logic              out_valid_q;
	dist_t             distance_q;
	logic [ROOT_W-1:0] root_fixed_q;
	logic              overflow_q;

	dist_t             sum;
	dist_t             total_nxt;
	logic              sat_nxt;
	logic [RAD_W:0]    trial;
	logic              fits;
	rad_t              res_nxt;
	logic              post_go;

	always_comb begin
		sum = total_q + {{(DIST_W-4){1'b0}}, pop8(diff_q[7:0])};
		if (sum > DIST_LIMIT) begin
			total_nxt = DIST_LIMIT;
			sat_nxt   = 1'b1;
		end else begin
			total_nxt = sum;
			sat_nxt   = sat_q;
		end
	end

	always_comb begin
		trial = {1'b0, res_q} + {1'b0, bit_q};
		fits  = {1'b0, rem_q} >= trial;
		if (fits) begin
			res_nxt = (res_q >> 1) + bit_q;
		end else begin
			res_nxt = res_q >> 1;
		end
	end

	assign post_go = (state_q == ST_POST) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_en_q <= 1'b0;
		end else if (cfg_valid) begin
			root_en_q <= root_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			byte_q  <= 3'd0;
			total_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						byte_q  <= 3'd0;
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					total_q <= total_nxt;
					sat_q   <= sat_nxt;
					byte_q  <= byte_q + 3'd1;
					if (byte_q == 3'd7) begin
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (root_en_q) begin
							state_q <= ST_ROOT;
						end else begin
							state_q <= ST_POST;
						end
					end
				end
				ST_ROOT: begin
					if (bit_q[0]) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					// clear the vector state once the result moves out
					if (post_go) begin
						total_q <= '0;
						sat_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					diff_q <= left_word ^ right_word;
					last_q <= last_word;
				end
			end
			ST_COUNT: begin
				diff_q <= diff_q >> 8;
				if (byte_q == 3'd7) begin
					rem_q  <= {total_nxt, 32'd0};
					res_q  <= '0;
					bit_q  <= {1'b1, {(RAD_W-1){1'b0}}};
					root_q <= '0;
				end
			end
			ST_ROOT: begin
				if (fits) begin
					rem_q <= rem_q - trial[RAD_W-1:0];
				end
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					root_q <= res_nxt[ROOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_go) begin
			distance_q   <= total_q;
			root_fixed_q <= root_q;
			overflow_q   <= sat_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign distance   = distance_q;
	assign root_fixed = root_fixed_q;
	assign overflow   = overflow_q;

	`ASSERT_ALWAYS(a_total_range, clk, arst_n, total_q <= DIST_LIMIT)
	`ASSERT_IMPLY(a_ovf_at_limit, clk, arst_n, out_valid && overflow, distance == DIST_LIMIT)
	`ASSERT_IMPLY(a_zero_root, clk, arst_n, out_valid && distance == '0, root_fixed == '0)
	`ASSERT_IMPLY(a_root_bit, clk, arst_n, state_q == ST_ROOT, $onehot(bit_q))

endmodule

// ===== tb/sv/hda_checker.sv =====
// Checker for the Hamming distance accumulator: predicts each vector result and compares it.
module hda_checker
	import hda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              root_enable,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [WORD_W-1:0] left_word,
	input  logic [WORD_W-1:0] right_word,
	input  logic              last_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  dist_t             distance,
	input  logic [ROOT_W-1:0] root_fixed,
	input  logic              overflow,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		dist_t             distance;
		logic [ROOT_W-1:0] root;
		logic              ovf;
	} vec_result_t;

	vec_result_t expected_vec_q[$];
	vec_result_t want;
	dist_t       total;
	logic        total_sat;
	logic        root_on;
	int          sum;
	int          fails;

	function automatic int ones_in(input logic [WORD_W-1:0] w);
		int n;
		n = 0;
		for (int i = 0; i < WORD_W; i++) begin
			n += w[i];
		end
		return n;
	endfunction

	// floor(sqrt(d) * 2^16) as the integer root of d << 32
	function automatic logic [ROOT_W-1:0] root_16_16(input dist_t d);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] probe;
		v = {15'd0, d, 32'd0};
		res = '0;
		probe = 64'd1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res[ROOT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total = '0;
			total_sat = 1'b0;
			root_on = 1'b0;
			expected_vec_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			fails = fail_count;
			if (cfg_valid && cfg_ready) root_on = root_enable;

			if (out_valid && out_ready) begin
				if (expected_vec_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual distance %0d root %0d overflow %0b",
						$time, distance, root_fixed, overflow);
					fails++;
				end else begin
					want = expected_vec_q.pop_front();
					if (distance !== want.distance) begin
						$display("%0t: distance mismatch: expected %0d, actual %0d",
							$time, want.distance, distance);
						fails++;
					end
					if (root_fixed !== want.root) begin
						$display("%0t: root_fixed mismatch: expected %0d, actual %0d",
							$time, want.root, root_fixed);
						fails++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t: overflow mismatch: expected %0b, actual %0b",
							$time, want.ovf, overflow);
						fails++;
					end
				end
			end

			if (in_valid && in_ready) begin
				sum = int'(total) + ones_in(left_word ^ right_word);
				// hold at the limit and remember it for this vector
				if (sum > int'(DIST_LIMIT)) begin
					sum = int'(DIST_LIMIT);
					total_sat = 1'b1;
				end
				total = dist_t'(sum);
				if (last_word) begin
					want.distance = total;
					want.root = root_on ? root_16_16(total) : '0;
					want.ovf = total_sat;
					expected_vec_q.push_back(want);
					total = '0;
					total_sat = 1'b0;
				end
			end

			fail_count <= fails;
			pending <= expected_vec_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the Hamming distance accumulator: stimulus, idling and verdict.
module tb;
	import hda_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 60;
	localparam int RAND_ITEMS  = 700;
	localparam int PHASES      = 6;

	localparam int DIFF_NONE = 0;
	localparam int DIFF_ALL  = 1;
	localparam int DIFF_ONE  = 2;
	localparam int DIFF_HALF = 3;
	localparam int DIFF_ANY  = 4;
	localparam int DIFF_MIX  = 5;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              root_enable;
	logic              in_valid;
	logic              in_ready;
	logic [WORD_W-1:0] left_word;
	logic [WORD_W-1:0] right_word;
	logic              last_word;
	logic              out_valid;
	logic              out_ready;
	dist_t             distance;
	logic [ROOT_W-1:0] root_fixed;
	logic              overflow;
	int                fail_count;
	int                pending;
	logic              send_idle_on;
	logic              sink_idle_on;
	int                cycles = 0;

	hamming_distance_accumulator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.root_enable(root_enable),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_word  (left_word),
		.right_word (right_word),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.distance   (distance),
		.root_fixed (root_fixed),
		.overflow   (overflow)
	);

	hda_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.root_enable(root_enable),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_word  (left_word),
		.right_word (right_word),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.distance   (distance),
		.root_fixed (root_fixed),
		.overflow   (overflow),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_idle_on) out_ready <= ($urandom_range(99) >= 28);
		else out_ready <= 1'b1;
	end

	task automatic send_pair(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r,
			input logic last);
		while (send_idle_on && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		left_word <= l;
		right_word <= r;
		last_word <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid and wait until every vector result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_root(input logic v);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		root_enable <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] diff_pattern(input int kind);
		case (kind)
			DIFF_NONE: return '0;
			DIFF_ALL:  return '1;
			DIFF_ONE:  return 64'd1 << $urandom_range(WORD_W-1);
			DIFF_HALF: return {32'd0, $urandom};
			default:   return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_vector(input int n, input int kind);
		logic [WORD_W-1:0] l;
		int                k;
		for (int i = 0; i < n; i++) begin
			k = (kind == DIFF_MIX) ? $urandom_range(DIFF_ANY, DIFF_NONE) : kind;
			case ($urandom_range(7))
				0:       l = '0;
				1:       l = '1;
				default: l = {$urandom, $urandom};
			endcase
			if (k == DIFF_HALF) l[WORD_W-1:32] = '0;
			send_pair(l, l ^ diff_pattern(k), i == n - 1);
		end
	endtask

	initial begin
		int done;
		int len;

		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		root_enable <= 1'b0;
		in_valid <= 1'b0;
		left_word <= '0;
		right_word <= '0;
		last_word <= 1'b0;
		out_ready <= 1'b0;
		send_idle_on <= 1'b1;
		sink_idle_on <= 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes with the root on, then off
		write_root(1'b1);
		send_pair('0, '0, 1'b1);
		send_pair('1, '0, 1'b1);
		send_pair('1, '1, 1'b1);
		send_pair({16{4'h5}}, {16{4'hA}}, 1'b1);
		send_pair(64'd1, 64'd1 << 63, 1'b1);
		send_pair({32'd0, $urandom}, {32'd0, $urandom}, 1'b1);
		send_pair('1, '0, 1'b0);
		send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		send_pair('0, 64'd1 << 40, 1'b1);
		write_root(1'b0);
		send_pair('1, '0, 1'b1);
		send_pair('0, 64'd1 << 63, 1'b1);
		send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);

		// total of exactly 65536, then a saturating vector, a clean one, a saturating one with root off
		write_root(1'b1);
		send_idle_on <= 1'b0;
		send_vector(1024, DIFF_ALL);
		send_vector(1030, DIFF_ALL);
		send_vector(1, DIFF_ONE);
		write_root(1'b0);
		send_vector(1025, DIFF_ALL);
		send_idle_on <= 1'b1;

		done = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_root(ph[0] ? 1'b0 : 1'b1);
			// one phase with no idling on either side
			send_idle_on <= (ph != 2);
			sink_idle_on <= (ph != 2);
			while (done < (ph + 1) * RAND_ITEMS / PHASES) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
				send_vector(len, DIFF_MIX);
				done += len;
				if ($urandom_range(29) == 0) drain_results();
			end
		end
		send_idle_on <= 1'b1;
		sink_idle_on <= 1'b1;

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== hamming_distance_accumulator.f =====
+incdir+hw/rtl
hw/rtl/hda_pkg.sv
hw/rtl/hamming_distance_accumulator.sv
tb/sv/hda_checker.sv
tb/sv/tb.sv
